### rtl/fpdb_pkg.sv
// Shared types and constants for the frame power meter.
// Holds the frame record, back-end state codes and the log2 fraction table.
// No dependencies.
`timescale 1ns / 1ps

package fpdb_pkg;

	// accumulator and sample widths
	localparam int ENERGY_W = 62;
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int SQ_W     = 31;   // |sample|^2 <= 2^30
	localparam int PROD_W   = 46;   // |sample|^2 * weight < 2^46
	localparam int DB_W     = 17;
	localparam int OFFS_W   = 16;
	localparam int RAW_W    = 16;   // raw dB never exceeds about 47780

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

	// frame queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// log2 fraction table: 2^TAB_BITS + 1 entries, Q30
	localparam int TAB_BITS  = 8;
	localparam int TAB_SIZE  = (1 << TAB_BITS) + 1;
	localparam int TAB_IDX_W = TAB_BITS + 1;
	localparam int LOG_W     = 31;
	localparam int FRAC_W    = 16;
	localparam int EXP_W     = 6;
	localparam int L2_W      = 36;   // e<<30 + fraction, e <= 61

	// 10*log10(2)*256 in Q16
	localparam logic [25:0] DB_PER_LOG2 = 26'd50504453;
	localparam int MUL_SPLIT = 18;
	localparam int MUL_W     = MUL_SPLIT + 26;

	localparam logic signed [DB_W-1:0] SILENT_DB     = -17'sd30720;
	localparam logic [OFFS_W-1:0]      DB_OFFSET_RST = 16'd34678;

	// normalizer runs six halving steps: 32, 16, 8, 4, 2, 1
	localparam logic [2:0] NORM_LAST = 3'd5;

	typedef struct packed {
		logic [ENERGY_W-1:0] sum;
		logic                clip;
	} fpdb_rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_LOOKUP,
		ST_INTERP,
		ST_LOG2,
		ST_MULT,
		ST_SUM,
		ST_DONE
	} back_state_t;

	typedef logic [LOG_W-1:0] log_tab_t [0:TAB_SIZE-1];

	// log2(1 + i/2^TAB_BITS) in Q30 by repeated squaring, fraction truncated
	function automatic log_tab_t build_log_tab();
		log_tab_t        t;
		logic [63:0]     v;
		logic [LOG_W-1:0] y;
		for (int i = 0; i < (1 << TAB_BITS); i++) begin
			v = 64'((1 << TAB_BITS) + i) << (30 - TAB_BITS);
			y = '0;
			for (int k = 1; k <= 30; k++) begin
				v = (v * v) >> 30;
				if (v >= (64'd1 << 31)) begin
					v = v >> 1;
					y = y | (LOG_W'(1) << (30 - k));
				end
			end
			t[i] = y;
		end
		t[TAB_SIZE-1] = LOG_W'(1) << 30;
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

### rtl/frame_power_db_meter.sv
// Top level of the frame power meter: offset register and the three parts.
// Depends on fpdb_pkg, fpdb_front, fpdb_queue and fpdb_back.
`timescale 1ns / 1ps

// Usage:
// Samples enter through a queue-style port: a beat is taken when push is high
// and full is low. Each beat carries a Q15 sample, its Q1.15 window weight and
// a frame_end mark. The front end takes one sample every cycle while full is
// low; its square and weight multiplies run in a three-stage pipeline ahead
// of the accumulator. Each frame end puts the frame energy in a four-deep
// record queue. full rises only while four frame records are queued or still
// in the pipeline. The back end works on one frame at a time, through the
// six-step leading-one search and the table/multiply sequence.
// Results leave through empty/pop: the result ports are valid while empty is
// low, and a beat is taken when pop is high. While the receiver does not pop,
// the back end holds its next result and the queue fills; then full rises.
// Samples of frames without a frame end are never lost, only held by full.
// db_offset is written through cfg_valid/cfg_ready, always ready; write it
// only while the block is idle. Reset clears the accumulator, the queue and
// the result valid flag and sets db_offset to 34678.

module frame_power_db_meter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [fpdb_pkg::SAMPLE_W-1:0] sample,
	input  logic [fpdb_pkg::WEIGHT_W-1:0]      weight,
	input  logic                               frame_end,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [fpdb_pkg::DB_W-1:0]   power_db,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpdb_pkg::OFFS_W-1:0]        cfg_data
);

	logic [fpdb_pkg::OFFS_W-1:0] db_offset_q;
	logic                        q_push;
	logic                        q_pop;
	logic                        q_valid;
	logic [fpdb_pkg::QCNT_W-1:0] q_count;
	fpdb_pkg::fpdb_rec_t         q_in;
	fpdb_pkg::fpdb_rec_t         q_out;

	// offset register, written on a config beat
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_offset_q <= fpdb_pkg::DB_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			db_offset_q <= cfg_data;
		end
	end

	fpdb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.weight    (weight),
		.frame_end (frame_end),
		.q_count   (q_count),
		.q_push    (q_push),
		.q_rec     (q_in)
	);

	fpdb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.rec_in  (q_in),
		.pop     (q_pop),
		.valid   (q_valid),
		.rec_out (q_out),
		.count   (q_count)
	);

	fpdb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rec     (q_out),
		.q_pop     (q_pop),
		.db_offset (db_offset_q),
		.empty     (empty),
		.pop       (pop),
		.power_db  (power_db),
		.saturated (saturated)
	);

endmodule

### rtl/fpdb_front.sv
// Front end: three-stage weighted-square pipeline and saturating accumulator.
// Pushes one frame record per frame end into the frame queue. Uses fpdb_pkg.
`timescale 1ns / 1ps

module fpdb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [fpdb_pkg::SAMPLE_W-1:0] sample,
	input  logic [fpdb_pkg::WEIGHT_W-1:0]     weight,
	input  logic                              frame_end,
	input  logic [fpdb_pkg::QCNT_W-1:0]       q_count,
	output logic                              q_push,
	output fpdb_pkg::fpdb_rec_t               q_rec
);

	logic                              take;
	logic [fpdb_pkg::QCNT_W-1:0]       pending;

	logic                              v_s1, v_s2, v_s3;
	logic                              fe_s1, fe_s2, fe_s3;
	logic [fpdb_pkg::SAMPLE_W-1:0]     mag_s1;
	logic [fpdb_pkg::WEIGHT_W-1:0]     w_s1, w_s2;
	logic [fpdb_pkg::SQ_W-1:0]         sq_s2;
	logic [fpdb_pkg::PROD_W-1:0]       p_s3;

	logic [2*fpdb_pkg::SAMPLE_W-1:0]   sq_full;
	logic [fpdb_pkg::SQ_W+fpdb_pkg::WEIGHT_W-1:0] p_full;

	logic [fpdb_pkg::ENERGY_W-1:0]     sum_q;
	logic                              clip_q;
	logic [fpdb_pkg::ENERGY_W:0]       sum_add;
	logic                              ovf;
	logic [fpdb_pkg::ENERGY_W-1:0]     sum_next;
	logic                              clip_next;

	// credit check: queued frames plus frame ends still in the pipeline
	assign pending = q_count + fpdb_pkg::QCNT_W'(fe_s1 & v_s1)
		+ fpdb_pkg::QCNT_W'(fe_s2 & v_s2) + fpdb_pkg::QCNT_W'(fe_s3 & v_s3);
	assign full = (pending >= fpdb_pkg::QCNT_W'(fpdb_pkg::QDEPTH));
	assign take = push & ~full;

	// pipeline valid and frame-end marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			fe_s1 <= 1'b0;
			fe_s2 <= 1'b0;
			fe_s3 <= 1'b0;
		end else begin
			v_s1  <= take;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			fe_s1 <= frame_end;
			fe_s2 <= fe_s1;
			fe_s3 <= fe_s2;
		end
	end

	// magnitude, square, weighted product
	assign sq_full = mag_s1 * mag_s1;
	assign p_full  = sq_s2 * w_s2;

	always_ff @(posedge clk) begin
		mag_s1 <= sample[fpdb_pkg::SAMPLE_W-1] ? (fpdb_pkg::SAMPLE_W'(0) - sample) : sample;
		w_s1   <= weight;
		sq_s2  <= sq_full[fpdb_pkg::SQ_W-1:0];
		w_s2   <= w_s1;
		p_s3   <= p_full[fpdb_pkg::PROD_W-1:0];
	end

	// saturating accumulate
	assign sum_add   = {1'b0, sum_q} + (fpdb_pkg::ENERGY_W+1)'(p_s3);
	assign ovf       = sum_add[fpdb_pkg::ENERGY_W];
	assign sum_next  = ovf ? fpdb_pkg::ENERGY_MAX : sum_add[fpdb_pkg::ENERGY_W-1:0];
	assign clip_next = clip_q | ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else if (v_s3) begin
			if (fe_s3) begin
				sum_q  <= '0;
				clip_q <= 1'b0;
			end else begin
				sum_q  <= sum_next;
				clip_q <= clip_next;
			end
		end
	end

	assign q_push   = v_s3 & fe_s3;
	assign q_rec.sum  = sum_next;
	assign q_rec.clip = clip_next;

endmodule

### rtl/fpdb_queue.sv
// Four-entry frame record queue between front and back end.
// Uses fpdb_pkg for the record type and depth.
`timescale 1ns / 1ps

module fpdb_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  fpdb_pkg::fpdb_rec_t         rec_in,
	input  logic                        pop,
	output logic                        valid,
	output fpdb_pkg::fpdb_rec_t         rec_out,
	output logic [fpdb_pkg::QCNT_W-1:0] count
);

	fpdb_pkg::fpdb_rec_t         ent_q [fpdb_pkg::QDEPTH];
	logic [fpdb_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [fpdb_pkg::QCNT_W-1:0] cnt_q;
	logic                        do_pop;

	assign valid   = (cnt_q != '0);
	assign do_pop  = pop & valid;
	assign rec_out = ent_q[rd_ptr_q];
	assign count   = cnt_q;

	// storage, written only on push (front never overfills by credit)
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= rec_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + fpdb_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + fpdb_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + fpdb_pkg::QCNT_W'(push) - fpdb_pkg::QCNT_W'(do_pop);
		end
	end

endmodule

### rtl/fpdb_back.sv
// Back end: sequencer that turns one frame energy into dB and holds the result.
// Normalizer, table interpolation, split constant multiply. Uses fpdb_pkg.
`timescale 1ns / 1ps

module fpdb_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  fpdb_pkg::fpdb_rec_t                q_rec,
	output logic                               q_pop,
	input  logic [fpdb_pkg::OFFS_W-1:0]        db_offset,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [fpdb_pkg::DB_W-1:0]   power_db,
	output logic                               saturated
);

	fpdb_pkg::back_state_t state_q, state_nxt;
	logic [2:0]            step_q;
	logic                  out_valid_q;
	logic                  out_load;
	logic                  out_take;

	logic [fpdb_pkg::ENERGY_W-1:0]  m_q;
	logic [fpdb_pkg::EXP_W-1:0]     e_q;
	logic                           clip_q;
	logic                           silent_q;
	logic [fpdb_pkg::LOG_W-1:0]     lo_q, diff_q;
	logic [fpdb_pkg::FRAC_W-1:0]    frac_q;
	logic [fpdb_pkg::LOG_W+fpdb_pkg::FRAC_W-1:0] ip_q;
	logic [fpdb_pkg::L2_W-1:0]      l2_q;
	logic [fpdb_pkg::MUL_W-1:0]     pl_q, ph_q;
	logic [fpdb_pkg::RAW_W-1:0]     raw_q;

	logic                           norm_zero;
	logic [fpdb_pkg::ENERGY_W-1:0]  norm_m;
	logic [fpdb_pkg::EXP_W-1:0]     norm_k;
	logic [fpdb_pkg::TAB_IDX_W-1:0] idx_lo, idx_hi;
	logic [fpdb_pkg::LOG_W-1:0]     tab_lo, tab_hi;
	logic [fpdb_pkg::ENERGY_W:0]    total;
	logic [fpdb_pkg::DB_W-1:0]      db_diff;

	assign out_take = pop & out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fpdb_pkg::ST_IDLE:   if (q_valid) state_nxt = fpdb_pkg::ST_NORM;
			fpdb_pkg::ST_NORM:   if (step_q == fpdb_pkg::NORM_LAST) state_nxt = fpdb_pkg::ST_LOOKUP;
			fpdb_pkg::ST_LOOKUP: state_nxt = fpdb_pkg::ST_INTERP;
			fpdb_pkg::ST_INTERP: state_nxt = fpdb_pkg::ST_LOG2;
			fpdb_pkg::ST_LOG2:   state_nxt = fpdb_pkg::ST_MULT;
			fpdb_pkg::ST_MULT:   state_nxt = fpdb_pkg::ST_SUM;
			fpdb_pkg::ST_SUM:    state_nxt = fpdb_pkg::ST_DONE;
			fpdb_pkg::ST_DONE:   if (!out_valid_q || out_take) state_nxt = fpdb_pkg::ST_IDLE;
			default:             state_nxt = fpdb_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			fpdb_pkg::ST_IDLE: q_pop    = q_valid;
			fpdb_pkg::ST_DONE: out_load = !out_valid_q || out_take;
			default: begin
				q_pop    = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpdb_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == fpdb_pkg::ST_NORM) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// one halving step of the leading-one search
	always_comb begin
		norm_zero = 1'b0;
		norm_m    = m_q;
		norm_k    = '0;
		case (step_q)
			3'd0: begin
				norm_zero = (m_q[61:30] == '0);
				norm_m    = m_q << 32;
				norm_k    = 6'd32;
			end
			3'd1: begin
				norm_zero = (m_q[61:46] == '0);
				norm_m    = m_q << 16;
				norm_k    = 6'd16;
			end
			3'd2: begin
				norm_zero = (m_q[61:54] == '0);
				norm_m    = m_q << 8;
				norm_k    = 6'd8;
			end
			3'd3: begin
				norm_zero = (m_q[61:58] == '0);
				norm_m    = m_q << 4;
				norm_k    = 6'd4;
			end
			3'd4: begin
				norm_zero = (m_q[61:60] == '0);
				norm_m    = m_q << 2;
				norm_k    = 6'd2;
			end
			3'd5: begin
				norm_zero = ~m_q[61];
				norm_m    = m_q << 1;
				norm_k    = 6'd1;
			end
			default: begin
				norm_zero = 1'b0;
			end
		endcase
	end

	// table reads at the mantissa index and the next entry
	assign idx_lo = {1'b0, m_q[60:53]};
	assign idx_hi = idx_lo + fpdb_pkg::TAB_IDX_W'(1);
	assign tab_lo = fpdb_pkg::LOG_TAB[idx_lo];
	assign tab_hi = fpdb_pkg::LOG_TAB[idx_hi];

	// recombine split product and round half up
	assign total = ({1'b0, ph_q, {fpdb_pkg::MUL_SPLIT{1'b0}}})
		+ (fpdb_pkg::ENERGY_W+1)'(pl_q)
		+ ((fpdb_pkg::ENERGY_W+1)'(1) << 45);

	assign db_diff = {1'b0, raw_q} - {1'b0, db_offset};

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			fpdb_pkg::ST_IDLE: begin
				m_q      <= q_rec.sum;
				clip_q   <= q_rec.clip;
				silent_q <= (q_rec.sum == '0);
				e_q      <= 6'd61;
			end
			fpdb_pkg::ST_NORM: begin
				if (norm_zero) begin
					m_q <= norm_m;
					e_q <= e_q - norm_k;
				end
			end
			fpdb_pkg::ST_LOOKUP: begin
				lo_q   <= tab_lo;
				diff_q <= tab_hi - tab_lo;
				frac_q <= m_q[52:37];
			end
			fpdb_pkg::ST_INTERP: begin
				ip_q <= diff_q * frac_q;
			end
			fpdb_pkg::ST_LOG2: begin
				l2_q <= {e_q, 30'd0} + fpdb_pkg::L2_W'(lo_q)
					+ fpdb_pkg::L2_W'(ip_q[fpdb_pkg::LOG_W+fpdb_pkg::FRAC_W-1:16]);
			end
			fpdb_pkg::ST_MULT: begin
				pl_q <= l2_q[fpdb_pkg::MUL_SPLIT-1:0] * fpdb_pkg::DB_PER_LOG2;
				ph_q <= l2_q[fpdb_pkg::L2_W-1:fpdb_pkg::MUL_SPLIT] * fpdb_pkg::DB_PER_LOG2;
			end
			fpdb_pkg::ST_SUM: begin
				raw_q <= total[46 +: fpdb_pkg::RAW_W];
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			power_db  <= silent_q ? fpdb_pkg::SILENT_DB : $signed(db_diff);
			saturated <= clip_q & ~silent_q;
		end
	end

	assign empty = ~out_valid_q;

endmodule

### test/frame_power_db_meter_tb.sv
// Self-checking testbench for frame_power_db_meter: directed table, then random frames.
// Checks every result beat against a directed row's typed value or an in-bench model
// of the frame energy and dB math. Depends on fpdb_pkg and frame_power_db_meter RTL.
`timescale 1ns / 1ps

module frame_power_db_meter_tb;

	localparam int           IDLE_PCT    = 32;
	localparam int           SETTLE_CYC  = 64;
	localparam int           HOLD_CYC    = 400;    // long receiver hold-off
	localparam int           WDOG_LIMIT  = 3000;
	localparam int           RAND_ITEMS  = 240;    // per random phase, five phases
	localparam logic [63:0]  ENERGY_TOP  = (64'd1 << 62) - 64'd1;
	localparam logic [63:0]  DB_OCT_Q16  = 64'd50504453;   // 10*log10(2)*256 in Q16
	localparam int           NUM_ROWS    = 18;

	typedef struct packed {
		logic signed [fpdb_pkg::DB_W-1:0] db;
		logic                             sat;
	} frame_result_t;

	// one directed row: sample repeated reps times, frame_end only on the last one
	typedef struct packed {
		logic [16:0]                           reps;
		logic signed [fpdb_pkg::SAMPLE_W-1:0]  smp;
		logic [fpdb_pkg::WEIGHT_W-1:0]         wt;
		logic                                  fe;
		logic                                  typed;
		logic signed [fpdb_pkg::DB_W-1:0]      db;
		logic                                  sat;
	} stim_row_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  push;
	logic                                  full;
	logic signed [fpdb_pkg::SAMPLE_W-1:0]  sample;
	logic [fpdb_pkg::WEIGHT_W-1:0]         weight;
	logic                                  frame_end;
	logic                                  empty;
	logic                                  pop;
	logic signed [fpdb_pkg::DB_W-1:0]      power_db;
	logic                                  saturated;
	logic                                  cfg_valid;
	logic                                  cfg_ready;
	logic [fpdb_pkg::OFFS_W-1:0]           cfg_data;

	// model state
	logic [63:0]                  meter_energy;
	logic                         meter_clip;
	logic [fpdb_pkg::OFFS_W-1:0]  meter_offset;
	logic [31:0]                  log2_frac_q30 [0:256];

	frame_result_t      frame_db_q [$];
	int                 fails = 0;
	bit                 idle_on = 1'b1;
	bit                 hold_req = 1'b0;
	int                 quiet_cycles = 0;

	stim_row_t dir_rows [0:NUM_ROWS-1] = '{
		// silent frame straight after reset
		'{17'd1,     16'sd0,      16'd32768, 1'b1, 1'b1, -17'sd30720, 1'b0},
		// smallest nonzero energy: log is zero, only the offset remains
		'{17'd1,     16'sd1,      16'd1,     1'b1, 1'b1, -17'sd34678, 1'b0},
		// full-scale sample with zero weight is silent
		'{17'd1,     16'sd32767,  16'd0,     1'b1, 1'b1, -17'sd30720, 1'b0},
		'{17'd1,     -16'sd32768, 16'd32768, 1'b1, 1'b0, 17'sd0,      1'b0},
		'{17'd1,     -16'sd32768, 16'd65535, 1'b1, 1'b0, 17'sd0,      1'b0},
		'{17'd1,     16'sd32767,  16'd65535, 1'b1, 1'b0, 17'sd0,      1'b0},
		// weight above unity
		'{17'd1,     -16'sd1,     16'd40000, 1'b1, 1'b0, 17'sd0,      1'b0},
		'{17'd3,     16'sd12345,  16'd32768, 1'b0, 1'b0, 17'sd0,      1'b0},
		'{17'd1,     -16'sd12345, 16'd16384, 1'b1, 1'b0, 17'sd0,      1'b0},
		// negative full scale, zero weight, then a zero sample: still silent
		'{17'd1,     -16'sd32768, 16'd0,     1'b0, 1'b0, 17'sd0,      1'b0},
		'{17'd1,     16'sd0,      16'd65535, 1'b1, 1'b1, -17'sd30720, 1'b0},
		'{17'd1,     16'sd2,      16'd1,     1'b1, 1'b0, 17'sd0,      1'b0},
		// long frame at full scale: large exponent
		'{17'd40,    -16'sd32768, 16'd65535, 1'b0, 1'b0, 17'sd0,      1'b0},
		'{17'd1,     16'sd32767,  16'd65535, 1'b1, 1'b0, 17'sd0,      1'b0},
		// accumulator must clear with the frame
		'{17'd1,     16'sd1,      16'd1,     1'b1, 1'b1, -17'sd34678, 1'b0},
		'{17'd1,     16'sd21845,  16'd43690, 1'b1, 1'b0, 17'sd0,      1'b0},
		'{17'd1,     -16'sd21846, 16'd21845, 1'b0, 1'b0, 17'sd0,      1'b0},
		'{17'd1,     16'sd181,    16'd32767, 1'b1, 1'b0, 17'sd0,      1'b0}
	};

	frame_power_db_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.weight    (weight),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop),
		.power_db  (power_db),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// log2(1 + i/256) in Q30 by repeated squaring, fraction truncated
	function automatic void fill_log2_frac();
		logic [63:0] v;
		logic [31:0] y;
		for (int i = 0; i < 256; i++) begin
			v = 64'(256 + i) << 22;
			y = '0;
			for (int k = 1; k <= 30; k++) begin
				v = (v * v) >> 30;
				if (v >= (64'd1 << 31)) begin
					v = v >> 1;
					y = y | (32'd1 << (30 - k));
				end
			end
			log2_frac_q30[i] = y;
		end
		log2_frac_q30[256] = 32'd1 << 30;
	endfunction

	// 10*log10(sum) in 1/256 dB minus offset, sum >= 1
	function automatic logic signed [fpdb_pkg::DB_W-1:0] energy_to_db(
			input logic [63:0] e_sum, input logic [fpdb_pkg::OFFS_W-1:0] offs);
		int          msb;
		logic [63:0] m, idx, fr, lo, hi, l2, raw;
		longint      d;
		msb = 61;
		while (msb > 0 && !e_sum[msb])
			msb--;
		m   = e_sum << (61 - msb);
		idx = (m >> 53) & 64'hFF;
		fr  = (m >> 37) & 64'hFFFF;
		lo  = 64'(log2_frac_q30[idx]);
		hi  = 64'(log2_frac_q30[idx + 1]);
		l2  = (64'(msb) << 30) + lo + (((hi - lo) * fr) >> 16);
		raw = (l2 * DB_OCT_Q16 + (64'd1 << 45)) >> 46;
		d   = longint'(raw) - longint'({48'd0, offs});
		return d[fpdb_pkg::DB_W-1:0];
	endfunction

	// accumulate one accepted sample; returns 1 when the frame closes
	function automatic bit accumulate_sample(input logic signed [fpdb_pkg::SAMPLE_W-1:0] s,
			input logic [fpdb_pkg::WEIGHT_W-1:0] w, input logic fe, output frame_result_t r);
		logic [63:0] mag, p;
		mag = (s < 0) ? 64'(-int'(s)) : 64'(int'(s));
		p   = mag * mag * 64'(w);
		r   = '0;
		if (p > ENERGY_TOP - meter_energy) begin
			meter_energy = ENERGY_TOP;
			meter_clip   = 1'b1;
		end else begin
			meter_energy = meter_energy + p;
		end
		if (!fe)
			return 1'b0;
		r.sat = meter_clip;
		r.db  = (meter_energy == 0) ? -17'sd30720 : energy_to_db(meter_energy, meter_offset);
		meter_energy = '0;
		meter_clip   = 1'b0;
		return 1'b1;
	endfunction

	// offer one sample beat, with random gaps, until the block takes it
	task automatic offer_sample(input logic signed [fpdb_pkg::SAMPLE_W-1:0] s,
			input logic [fpdb_pkg::WEIGHT_W-1:0] w, input logic fe, input bit typed,
			input frame_result_t typed_res);
		frame_result_t r;
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		sample    <= s;
		weight    <= w;
		frame_end <= fe;
		do @(posedge clk); while (full);
		if (accumulate_sample(s, w, fe, r))
			frame_db_q.insert(frame_db_q.size(), typed ? typed_res : r);
	endtask

	function automatic logic signed [fpdb_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [fpdb_pkg::WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 16'd32768;
			1: return 16'd0;
			2: return 16'd65535;
			3: return 16'($urandom_range(32769, 65535));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// random frames, mostly short, each closed with frame_end
	task automatic send_random_frames(input int n_items);
		int                                    done, len, r, kind;
		logic signed [fpdb_pkg::SAMPLE_W-1:0]  s;
		logic [fpdb_pkg::WEIGHT_W-1:0]         w;
		done = 0;
		while (done < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 8);
			else if (r < 92)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 300);
			kind = $urandom_range(0, 9);
			for (int i = 0; i < len; i++) begin
				case (kind)
					// silent frame: zero sample or zero weight on every beat
					0: begin
						if ($urandom_range(0, 1) != 0) begin
							s = '0;
							w = pick_weight();
						end else begin
							s = pick_sample();
							w = '0;
						end
					end
					// very low level, small exponents
					1: begin
						s = 16'(int'($urandom_range(0, 8)) - 4);
						w = 16'($urandom_range(0, 3));
					end
					default: begin
						s = pick_sample();
						w = pick_weight();
					end
				endcase
				offer_sample(s, w, i == len - 1, 1'b0, '0);
			end
			done += len;
		end
	endtask

	// wait for all results, then let the pipeline run dry
	task automatic drain_results();
		push <= 1'b0;
		while (frame_db_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_offset(input logic [fpdb_pkg::OFFS_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		meter_offset = v;
	endtask

	// result side: random pop, one long hold-off on request
	initial begin
		frame_result_t exp_res;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (frame_db_q.size() == 0) begin
					$error("result beat with no frame pending: power_db %0d saturated %0d",
						power_db, saturated);
					fails++;
				end else begin
					exp_res = frame_db_q.pop_front();
					if (power_db !== exp_res.db) begin
						$error("power_db mismatch: expected %0d, actual %0d",
							exp_res.db, power_db);
						fails++;
					end
					if (saturated !== exp_res.sat) begin
						$error("saturated mismatch: expected %0d, actual %0d",
							exp_res.sat, saturated);
						fails++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end
			pop <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// watchdog: cycles in a row with no beat on any channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// main sequence
	initial begin
		logic [fpdb_pkg::OFFS_W-1:0] offs_list [0:4];
		stim_row_t                   row;
		frame_result_t               typed_res;
		arst_n    = 1'b0;
		push      = 1'b0;
		sample    = '0;
		weight    = '0;
		frame_end = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		fill_log2_frac();
		meter_energy = '0;
		meter_clip   = 1'b0;
		meter_offset = 16'd34678;
		offs_list[0] = 16'd0;
		offs_list[1] = 16'd65535;
		offs_list[2] = 16'($urandom_range(0, 65535));
		offs_list[3] = 16'($urandom_range(0, 65535));
		offs_list[4] = fpdb_pkg::DB_OFFSET_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset offset
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = dir_rows[i];
			typed_res.db  = row.db;
			typed_res.sat = row.sat;
			for (int n = 1; n <= int'(row.reps); n++)
				offer_sample(row.smp, row.wt, row.fe && n == int'(row.reps),
					row.typed && n == int'(row.reps), typed_res);
		end

		// random phases, one offset each; phase 1 holds the receiver off, phase 2 never idles
		for (int ph = 0; ph < 5; ph++) begin
			drain_results();
			write_offset(offs_list[ph]);
			idle_on = (ph != 2);
			if (ph == 1)
				hold_req = 1'b1;
			send_random_frames(RAND_ITEMS);
		end
		idle_on = 1'b1;

		drain_results();
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
